/* hw/rtl/bmm_pkg.sv */
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants for the bipartite maximum matching block.
// ----------------------------------------------------------------------------
package bmm_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VTX_W        = 4;   // bits of a vertex index
  localparam int CNT_W        = 5;   // bits of a count up to MAX_VERTICES
  localparam int ROW_W        = 16;  // bits of one adjacency row
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  localparam logic [CNT_W-1:0] SIZE_RESET = 5'd16;
  localparam logic [CNT_W-1:0] SIZE_CAP   = 5'd16;

  // Register index codes.
  localparam logic REG_SIZE_IN_USE = 1'b0;

  // Command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  typedef struct packed {
    logic             command;
    logic [VTX_W-1:0] row_index;
    logic [ROW_W-1:0] edge_bits;
  } in_t;

  typedef struct packed {
    logic [VTX_W-1:0] column;
    logic             matched;
    logic [VTX_W-1:0] partner_row;
    logic [CNT_W-1:0] match_count;
    logic             last;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t word;
  } emit_t;

endpackage

/* hw/rtl/bmm_ram.sv */
// ----------------------------------------------------------------------------
// bmm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // The read data holds until the next read is issued.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/bmm_cfg.sv */
// ----------------------------------------------------------------------------
// bmm_cfg
// APB register file holding size_in_use and the clamped working size.
// ----------------------------------------------------------------------------
module bmm_cfg
  import bmm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CNT_W-1:0]   size
);

  logic [CNT_W-1:0] size_in_use;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1] == REG_SIZE_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      size_in_use <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = reg_hit ? {{(PDATA_W-CNT_W){1'b0}}, size_in_use} : '0;

  // A size of zero works as one; anything past the cap saturates.
  always_comb begin
    if (size_in_use == '0) begin
      size = CNT_W'(1);
    end else if (size_in_use > SIZE_CAP) begin
      size = SIZE_CAP;
    end else begin
      size = size_in_use;
    end
  end

endmodule

/* hw/rtl/bmm_solver.sv */
// ----------------------------------------------------------------------------
// bmm_solver
// Augmenting-path sequencer over the adjacency and match table memories,
// with an explicit frame stack for the depth-first search.
// ----------------------------------------------------------------------------
module bmm_solver
  import bmm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             load_we,
  input  logic [VTX_W-1:0] load_row,
  input  logic [ROW_W-1:0] load_bits,
  input  logic [CNT_W-1:0] size,
  input  logic             emit_take,
  output logic             busy,
  output emit_t            emit
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_ROOT       = 4'd1;
  localparam logic [3:0] S_ADJ_WAIT   = 4'd2;
  localparam logic [3:0] S_SCAN       = 4'd3;
  localparam logic [3:0] S_MATCH_WAIT = 4'd4;
  localparam logic [3:0] S_AUGMENT    = 4'd5;
  localparam logic [3:0] S_NEXT_ROOT  = 4'd6;
  localparam logic [3:0] S_EMIT_RD    = 4'd7;
  localparam logic [3:0] S_EMIT_WAIT  = 4'd8;

  logic [3:0]        state;
  logic [CNT_W-1:0]  n_size;
  logic [CNT_W-1:0]  root;
  logic [CNT_W-1:0]  col;
  logic [CNT_W-1:0]  depth;
  logic [CNT_W-1:0]  pair_total;
  logic [VTX_W-1:0]  aug_k;
  logic [ROW_W-1:0]  visited;
  logic [ROW_W-1:0]  valid_bits;
  logic [VTX_W-1:0]  stack_left  [MAX_VERTICES];
  logic [CNT_W-1:0]  stack_right [MAX_VERTICES];

  logic [VTX_W-1:0]  top_idx;
  logic [VTX_W-1:0]  cur_u;
  logic [CNT_W-1:0]  cur_v;
  logic [VTX_W-1:0]  v_idx;
  logic              v_out;
  logic              v_free;

  logic              adj_re;
  logic [VTX_W-1:0]  adj_raddr;
  logic [ROW_W-1:0]  adj_rdata;
  logic              match_we;
  logic [VTX_W-1:0]  match_waddr;
  logic              match_re;
  logic [VTX_W-1:0]  match_raddr;
  logic [VTX_W-1:0]  match_rdata;
  logic              col_last;

  assign top_idx = VTX_W'(depth - CNT_W'(1));
  assign cur_u   = stack_left[top_idx];
  assign cur_v   = stack_right[top_idx];
  assign v_idx   = cur_v[VTX_W-1:0];
  assign v_out   = (cur_v >= n_size);
  // adj_rdata still holds the row of the top frame's left vertex.
  assign v_free  = adj_rdata[v_idx] && !visited[v_idx];
  assign col_last = ((col + CNT_W'(1)) == n_size);

  assign busy = (state != S_IDLE);

  // Memory port selection.
  always_comb begin
    adj_re      = 1'b0;
    adj_raddr   = cur_u;
    match_re    = 1'b0;
    match_raddr = v_idx;
    case (state)
      S_ROOT: begin
        adj_re    = 1'b1;
        adj_raddr = root[VTX_W-1:0];
      end
      S_SCAN: begin
        if (v_out) begin
          adj_re    = (depth > CNT_W'(1));
          adj_raddr = stack_left[top_idx - VTX_W'(1)];
        end else if (v_free && valid_bits[v_idx]) begin
          match_re = (depth < CNT_W'(MAX_VERTICES));
        end
      end
      S_MATCH_WAIT: begin
        adj_re    = 1'b1;
        adj_raddr = match_rdata;
      end
      S_EMIT_RD: begin
        match_re    = 1'b1;
        match_raddr = col[VTX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign match_we    = (state == S_AUGMENT);
  assign match_waddr = stack_right[aug_k][VTX_W-1:0];

  bmm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_row),
    .wdata (load_bits),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  bmm_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_match_ram (
    .clk   (clk),
    .we    (match_we),
    .waddr (match_waddr),
    .wdata (stack_left[aug_k]),
    .re    (match_re),
    .raddr (match_raddr),
    .rdata (match_rdata)
  );

  always_comb begin
    emit.valid            = (state == S_EMIT_WAIT);
    emit.word.column      = col[VTX_W-1:0];
    emit.word.matched     = valid_bits[col[VTX_W-1:0]];
    emit.word.partner_row = valid_bits[col[VTX_W-1:0]] ? match_rdata : '0;
    emit.word.match_count = pair_total;
    emit.word.last        = col_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      depth      <= '0;
      pair_total <= '0;
      visited    <= '0;
      valid_bits <= '0;
      root       <= '0;
      col        <= '0;
      n_size     <= SIZE_RESET;
      aug_k      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            valid_bits <= '0;
            pair_total <= '0;
            root       <= '0;
            n_size     <= size;
            state      <= S_ROOT;
          end
        end
        S_ROOT: begin
          visited        <= '0;
          stack_left[0]  <= root[VTX_W-1:0];
          stack_right[0] <= '0;
          depth          <= CNT_W'(1);
          state          <= S_ADJ_WAIT;
        end
        S_ADJ_WAIT: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (v_out) begin
            // Frame exhausted: pop it and move its parent to the next column.
            depth <= depth - CNT_W'(1);
            if (depth == CNT_W'(1)) begin
              state <= S_NEXT_ROOT;
            end else begin
              stack_right[top_idx - VTX_W'(1)] <=
                stack_right[top_idx - VTX_W'(1)] + CNT_W'(1);
              state <= S_ADJ_WAIT;
            end
          end else if (v_free) begin
            visited[v_idx] <= 1'b1;
            if (!valid_bits[v_idx]) begin
              aug_k <= top_idx;
              state <= S_AUGMENT;
            end else if (depth < CNT_W'(MAX_VERTICES)) begin
              state <= S_MATCH_WAIT;
            end else begin
              stack_right[top_idx] <= cur_v + CNT_W'(1);
            end
          end else begin
            stack_right[top_idx] <= cur_v + CNT_W'(1);
          end
        end
        S_MATCH_WAIT: begin
          stack_left[depth[VTX_W-1:0]]  <= match_rdata;
          stack_right[depth[VTX_W-1:0]] <= '0;
          depth <= depth + CNT_W'(1);
          state <= S_ADJ_WAIT;
        end
        S_AUGMENT: begin
          // Each frame's column now pairs with that frame's left vertex.
          valid_bits[match_waddr] <= 1'b1;
          if (aug_k == '0) begin
            pair_total <= pair_total + CNT_W'(1);
            depth      <= '0;
            state      <= S_NEXT_ROOT;
          end else begin
            aug_k <= aug_k - VTX_W'(1);
          end
        end
        S_NEXT_ROOT: begin
          if ((root + CNT_W'(1)) >= n_size) begin
            col   <= '0;
            state <= S_EMIT_RD;
          end else begin
            root  <= root + CNT_W'(1);
            state <= S_ROOT;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (emit_take) begin
            col <= col + CNT_W'(1);
            if (col_last) begin
              state <= S_IDLE;
            end else begin
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/bipartite_max_matching_top.sv */
// ----------------------------------------------------------------------------
// bipartite_max_matching_top
// Maximum bipartite matching over a loaded adjacency matrix.
// ----------------------------------------------------------------------------
// A load word (command 0) writes one adjacency row; it is taken only while
// the block is idle. A solve word (command 1) runs an augmenting-path search
// for every left vertex in use and then returns one result word per right
// vertex, the last one flagged. req_ready stays low from the solve until its
// final result word has been handed to the output register. The solve is
// paced by the search sequencer and its registered memory reads: each left
// vertex starts with a root setup and a wait for its adjacency row, each
// column is tested in the scan state, each stack push reads the match table
// and then the new row, each pop back to a parent frame rereads the parent's
// row, an augment flips one edge per frame, and each result word reads the
// match table and then waits on any output stall, so solve time depends on the graph.
// ----------------------------------------------------------------------------
module bipartite_max_matching_top
  import bmm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_ready,
  input  in_t                req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output out_t               rsp
);

  logic             busy;
  logic             take;
  logic             emit_take;
  logic [CNT_W-1:0] size;
  emit_t            emit;

  assign req_ready = !busy;
  assign take      = req_valid && req_ready;
  assign emit_take = !rsp_valid || rsp_ready;

  bmm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size    (size)
  );

  bmm_solver u_solver (
    .clk       (clk),
    .rst       (rst),
    .start     (take && (req.command == CMD_SOLVE)),
    .load_we   (take && (req.command == CMD_LOAD)),
    .load_row  (req.row_index),
    .load_bits (req.edge_bits),
    .size      (size),
    .emit_take (emit_take),
    .busy      (busy),
    .emit      (emit)
  );

  // Output register: a result waits here while the sequencer moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_take) begin
      rsp_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take && emit.valid) begin
      rsp <= emit.word;
    end
  end

endmodule

/* tb/tb_bipartite_max_matching_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bipartite_max_matching_top
// Self-checking bench for the bipartite maximum matching block. Row loads and
// solve words go in over the request channel, the size register is set over
// the APB port while the block is idle, and every result word is compared
// field by field against an augmenting-path matcher in the bench or a typed
// table word. A short directed table comes first, then random phases with
// varied sizes and idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_bipartite_max_matching_top;
  import bmm_pkg::*;

  localparam int QUIET_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int WORDS_PER_SET = 10;
  localparam int SOLVE_PCT     = 30;
  localparam int DIR_LEN       = 26;

  localparam logic [PADDR_W-1:0] SIZE_ADDR = PADDR_W'(4 * int'(REG_SIZE_IN_USE));

  typedef enum logic [1:0] {STEP_CFG, STEP_LOAD, STEP_SOLVE} step_kind_t;

  typedef struct packed {
    step_kind_t         kind;
    logic [VTX_W-1:0]   row;
    logic [PDATA_W-1:0] data;
    logic               typed;
    out_t               want;
  } dir_step_t;

  localparam out_t LONE_UNMATCHED = '{column: 4'd0, matched: 1'b0, partner_row: 4'd0,
                                      match_count: 5'd0, last: 1'b1};
  localparam out_t LONE_MATCHED   = '{column: 4'd0, matched: 1'b1, partner_row: 4'd0,
                                      match_count: 5'd1, last: 1'b1};

  // Size 0 behaves as 1, and bits above the size in use are ignored. Then a
  // chain of rows forces long augmenting paths at the saturated size.
  localparam dir_step_t DIR_TAB [DIR_LEN] = '{
    '{STEP_CFG,   4'd0,  32'd0,      1'b0, '0},
    '{STEP_LOAD,  4'd0,  32'hFFFE,   1'b0, '0},
    '{STEP_SOLVE, 4'd0,  32'd0,      1'b1, LONE_UNMATCHED},
    '{STEP_LOAD,  4'd0,  32'h0001,   1'b0, '0},
    '{STEP_SOLVE, 4'd0,  32'd0,      1'b1, LONE_MATCHED},
    '{STEP_CFG,   4'd0,  32'd31,     1'b0, '0},
    '{STEP_LOAD,  4'd0,  32'hFFFF,   1'b0, '0},
    '{STEP_LOAD,  4'd1,  32'h0003,   1'b0, '0},
    '{STEP_LOAD,  4'd2,  32'h0006,   1'b0, '0},
    '{STEP_LOAD,  4'd3,  32'h000C,   1'b0, '0},
    '{STEP_LOAD,  4'd4,  32'h0018,   1'b0, '0},
    '{STEP_LOAD,  4'd5,  32'h0030,   1'b0, '0},
    '{STEP_LOAD,  4'd6,  32'h0060,   1'b0, '0},
    '{STEP_LOAD,  4'd7,  32'h00C0,   1'b0, '0},
    '{STEP_LOAD,  4'd8,  32'h0180,   1'b0, '0},
    '{STEP_LOAD,  4'd9,  32'h0300,   1'b0, '0},
    '{STEP_LOAD,  4'd10, 32'h0600,   1'b0, '0},
    '{STEP_LOAD,  4'd11, 32'h0C00,   1'b0, '0},
    '{STEP_LOAD,  4'd12, 32'h1800,   1'b0, '0},
    '{STEP_LOAD,  4'd13, 32'h3000,   1'b0, '0},
    '{STEP_LOAD,  4'd14, 32'h6000,   1'b0, '0},
    '{STEP_LOAD,  4'd15, 32'h0000,   1'b0, '0},
    '{STEP_SOLVE, 4'd0,  32'd0,      1'b0, '0},
    '{STEP_CFG,   4'd0,  32'd16,     1'b0, '0},
    '{STEP_LOAD,  4'd15, 32'h8000,   1'b0, '0},
    '{STEP_SOLVE, 4'd0,  32'd0,      1'b0, '0}
  };

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               req_valid;
  logic               req_ready;
  in_t                req;
  logic               rsp_valid;
  logic               rsp_ready;
  out_t               rsp;

  // Set alongside a solve word whose results are typed into the table.
  logic typed_chk;
  out_t typed_word;

  int tx_idle_pct;
  int rx_stall_pct;
  bit hold_req;
  int fail_count   = 0;
  int quiet_cycles = 0;

  logic [ROW_W-1:0] edge_rows [MAX_VERTICES];
  logic [CNT_W-1:0] size_reg;
  out_t             pairing_q [$];

  bipartite_max_matching_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Appends one expected result word at the tail of the queue.
  function automatic void queue_expected(input out_t w);
    pairing_q.insert(pairing_q.size(), w);
  endfunction

  // Kuhn's search with an explicit stack of (left vertex, next column) frames.
  // Every right vertex in use gets one expected result word.
  function automatic void predict_matching();
    int               n;
    int               root;
    int               top;
    int               cu;
    int               cv;
    int               depth;
    int               k;
    int               c;
    int               pairs;
    logic [MAX_VERTICES-1:0] seen;
    logic             found;
    logic             taken [MAX_VERTICES];
    logic [VTX_W-1:0] mate [MAX_VERTICES];
    int               frame_left [MAX_VERTICES];
    int               frame_col [MAX_VERTICES];
    out_t             word;
    n = int'(size_reg);
    if (n < 1) n = 1;
    if (n > MAX_VERTICES) n = MAX_VERTICES;
    for (k = 0; k < MAX_VERTICES; k++) begin
      taken[k] = 1'b0;
      mate[k]  = '0;
    end
    pairs = 0;
    for (root = 0; root < n; root++) begin
      seen          = '0;
      frame_left[0] = root;
      frame_col[0]  = 0;
      depth         = 1;
      found         = 1'b0;
      while (depth > 0 && !found) begin
        top = depth - 1;
        cu  = frame_left[top];
        cv  = frame_col[top];
        if (cv >= n) begin
          depth--;
          if (depth > 0) frame_col[depth-1]++;
        end else if (edge_rows[cu][cv] && !seen[cv]) begin
          seen[cv] = 1'b1;
          if (!taken[cv]) begin
            // Free column reached: flip every edge along the path.
            for (k = depth - 1; k >= 0; k--) begin
              mate[frame_col[k]]  = VTX_W'(frame_left[k]);
              taken[frame_col[k]] = 1'b1;
            end
            found = 1'b1;
          end else if (depth < MAX_VERTICES) begin
            frame_left[depth] = int'(mate[cv]);
            frame_col[depth]  = 0;
            depth++;
          end else begin
            frame_col[top]++;
          end
        end else begin
          frame_col[top]++;
        end
      end
      if (found) pairs++;
    end
    for (c = 0; c < n; c++) begin
      word.column      = VTX_W'(c);
      word.matched     = taken[c];
      word.partner_row = taken[c] ? mate[c] : '0;
      word.match_count = CNT_W'(pairs);
      word.last        = (c == n - 1);
      queue_expected(word);
    end
  endfunction

  function automatic logic [ROW_W-1:0] rand_edges();
    logic [ROW_W-1:0] bits;
    case ($urandom_range(3))
      0: begin
        bits = ROW_W'($urandom & $urandom);
      end
      1: begin
        bits = ROW_W'($urandom | $urandom);
      end
      2: begin
        bits = ROW_W'((1 << $urandom_range(15)) | (1 << $urandom_range(15)));
      end
      default: begin
        bits = ROW_W'($urandom);
      end
    endcase
    return bits;
  endfunction

  // Offers one word, with random idle cycles ahead of it, and returns at the
  // falling edge after it was taken.
  task automatic send_word(input in_t item, input logic typed, input out_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid  <= 1'b1;
    req        <= item;
    typed_chk  <= typed;
    typed_word <= want;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pairing_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SIZE_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    out_t want;
    logic moved;
    if (rst) begin
      size_reg     = SIZE_RESET;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (psel && penable && pwrite && pready) begin
        moved = 1'b1;
        if (paddr == SIZE_ADDR) size_reg = pwdata[CNT_W-1:0];
      end
      if (req_valid && req_ready) begin
        moved = 1'b1;
        if (req.command == CMD_LOAD) begin
          edge_rows[req.row_index] = req.edge_bits;
        end else if (typed_chk) begin
          queue_expected(typed_word);
        end else begin
          predict_matching();
        end
      end
      if (rsp_valid && rsp_ready) begin
        moved = 1'b1;
        if (pairing_q.size() == 0) begin
          $error("result word with none expected: column %0d", rsp.column);
          fail_count++;
        end else begin
          want = pairing_q.pop_front();
          if (rsp.column !== want.column) begin
            $error("column: expected %0d, got %0d", want.column, rsp.column);
            fail_count++;
          end
          if (rsp.matched !== want.matched) begin
            $error("matched: expected %0d, got %0d", want.matched, rsp.matched);
            fail_count++;
          end
          if (rsp.partner_row !== want.partner_row) begin
            $error("partner_row: expected %0d, got %0d", want.partner_row, rsp.partner_row);
            fail_count++;
          end
          if (rsp.match_count !== want.match_count) begin
            $error("match_count: expected %0d, got %0d", want.match_count, rsp.match_count);
            fail_count++;
          end
          if (rsp.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp.last);
            fail_count++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb_bipartite_max_matching_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    in_t item;
    int  k;
    int  p;
    int  s;
    int  sz;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_valid    = 1'b0;
    req          = '0;
    typed_chk    = 1'b0;
    typed_word   = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (k = 0; k < DIR_LEN; k++) begin
      case (DIR_TAB[k].kind)
        STEP_CFG: begin
          wait_idle();
          reg_write(DIR_TAB[k].data);
        end
        STEP_LOAD: begin
          item.command   = CMD_LOAD;
          item.row_index = DIR_TAB[k].row;
          item.edge_bits = DIR_TAB[k].data[ROW_W-1:0];
          send_word(item, 1'b0, '0);
        end
        default: begin
          item.command   = CMD_SOLVE;
          item.row_index = VTX_W'($urandom_range(15));
          item.edge_bits = rand_edges();
          send_word(item, DIR_TAB[k].typed, DIR_TAB[k].want);
        end
      endcase
    end

    // Every row is loaded by now, so any size may be solved from here on.
    for (p = 0; p < 4; p++) begin
      tx_idle_pct  = (p == 1) ? 64 : (p == 3) ? 33 : 0;
      rx_stall_pct = (p == 2) ? 64 : (p == 3) ? 33 : 0;
      for (s = 0; s < 2; s++) begin
        case (p)
          0: sz = 16;
          1: sz = $urandom_range(2, 15);
          2: sz = 1;
          default: sz = $urandom_range(17, 31);
        endcase
        if (s == 1) sz = $urandom_range(0, 31);
        wait_idle();
        reg_write(PDATA_W'(sz));
        if (p == 0 && s == 0) begin
          // Results are held back for a long stretch while words keep coming.
          @(posedge clk);
          hold_req = 1'b1;
          @(negedge clk);
        end
        for (k = 0; k < WORDS_PER_SET; k++) begin
          if ((p == 0 && s == 0 && k == 0) || $urandom_range(99) < SOLVE_PCT)
            item.command = CMD_SOLVE;
          else
            item.command = CMD_LOAD;
          item.row_index = VTX_W'($urandom_range(15));
          item.edge_bits = rand_edges();
          send_word(item, 1'b0, '0);
        end
      end
    end

    req_valid <= 1'b0;
    while (pairing_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_bipartite_max_matching_top OK");
    else
      $display("tb_bipartite_max_matching_top NOT OK");
    $finish;
  end

endmodule

/* bipartite_max_matching_top.f */
hw/rtl/bmm_pkg.sv
hw/rtl/bmm_ram.sv
hw/rtl/bmm_cfg.sv
hw/rtl/bmm_solver.sv
hw/rtl/bipartite_max_matching_top.sv
tb/tb_bipartite_max_matching_top.sv
